// ----- rtl/klx_pkg.sv -----
// ----------------------------------------------------------------------------
// klx_pkg
// Shared types, token codes and keyword tables for the keyword lexer.
// ----------------------------------------------------------------------------
package klx_pkg;

  localparam int KEYWORD_MAX_DEF = 5;   // longest identifier held for matching
  localparam int CMDQ_DEPTH      = 4;   // words between front and back
  localparam int NUM_KW          = 12;
  localparam int KW_TEXT_MAX     = 5;   // longest keyword

  // token codes
  localparam logic [5:0] K_LT     = 6'd0;
  localparam logic [5:0] K_LE     = 6'd1;
  localparam logic [5:0] K_GT     = 6'd2;
  localparam logic [5:0] K_GE     = 6'd3;
  localparam logic [5:0] K_SEMI   = 6'd4;
  localparam logic [5:0] K_POPEN  = 6'd5;
  localparam logic [5:0] K_PCLOSE = 6'd6;
  localparam logic [5:0] K_MOD    = 6'd7;
  localparam logic [5:0] K_MULT   = 6'd8;
  localparam logic [5:0] K_DIV    = 6'd9;
  localparam logic [5:0] K_ASSIGN = 6'd10;
  localparam logic [5:0] K_EQ     = 6'd11;
  localparam logic [5:0] K_ADD    = 6'd12;
  localparam logic [5:0] K_INC    = 6'd13;
  localparam logic [5:0] K_SUB    = 6'd14;
  localparam logic [5:0] K_DEC    = 6'd15;
  localparam logic [5:0] K_ERROR  = 6'd16;
  localparam logic [5:0] K_NE     = 6'd17;
  localparam logic [5:0] K_ID     = 6'd18;
  localparam logic [5:0] K_INT    = 6'd19;
  localparam logic [5:0] K_STRING = 6'd20;
  localparam logic [5:0] K_KW0    = 6'd21;
  localparam logic [5:0] K_END    = 6'd33;

  // one result word
  typedef struct packed {
    logic [5:0] kind;
    logic [7:0] text_char;
    logic       has_char;
    logic       last;
  } tok_t;

  // keyword text, first character at index 0, padded with zeros
  typedef logic [0:KW_TEXT_MAX-1][7:0] kw_text_t;

  localparam kw_text_t KW_TEXT [NUM_KW] = '{
    "print",          {"if", 24'h0},   {"then", 8'h0},  {"else", 8'h0},
    {"get", 16'h0},   {"end", 16'h0},  "while",         {"do", 24'h0},
    {"for", 16'h0},   {"and", 16'h0},  {"or", 24'h0},   {"not", 16'h0}
  };

  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd5, 3'd2, 3'd4, 3'd4, 3'd3, 3'd3, 3'd5, 3'd2, 3'd3, 3'd3, 3'd2, 3'd3
  };

endpackage

// ----- rtl/klx_front.sv -----
// ----------------------------------------------------------------------------
// klx_front
// Scanner front end: classifies each byte, keeps the token in progress and
// builds one command word listing the results that the byte releases.
// ----------------------------------------------------------------------------
module klx_front #(
  parameter int  KeywordMax = klx_pkg::KEYWORD_MAX_DEF,
  localparam int CntW       = $clog2(KeywordMax + 2)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             take,
  input  logic [7:0]                       ch,
  input  logic                             end_of_input,
  output logic                             cmd_push,
  output klx_pkg::tok_t [KeywordMax:0]     cmd_ents,
  output logic [CntW-1:0]                  cmd_n
);

  localparam int IdxW    = $clog2(KeywordMax + 1);
  localparam int WcW     = $clog2(KeywordMax + 1);
  localparam int BufIdxW = $clog2(KeywordMax);

  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_POPEN  = 8'h28;
  localparam logic [7:0] CH_PCLOSE = 8'h29;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_OP     = 5'b00010,
    MODE_IDENT  = 5'b00100,
    MODE_INT    = 5'b01000,
    MODE_STRING = 5'b10000
  } mode_t;

  function automatic klx_pkg::tok_t mk(input logic [5:0] k, input logic [7:0] c,
                                       input logic h, input logic l);
    klx_pkg::tok_t t;
    t.kind      = k;
    t.text_char = h ? c : 8'h00;
    t.has_char  = h;
    t.last      = l;
    return t;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  mode_t           mode, mode_next;
  logic [7:0]      pend, pend_next;
  logic [7:0]      wbuf [KeywordMax];
  logic [7:0]      wbuf_next [KeywordMax];
  logic [WcW-1:0]  wcnt, wcnt_next;
  logic            wlong, wlong_next;

  logic                          kw_hit;
  logic [3:0]                    kw_idx;
  klx_pkg::tok_t [KeywordMax-1:0] fl_ents;
  logic [CntW-1:0]               fl_n;
  klx_pkg::tok_t                 str_fl;
  logic [7:0]                    op_second;
  logic [5:0]                    op_two, op_one;
  mode_t                         st_mode;
  logic                          st_emit;
  logic [5:0]                    st_kind;
  klx_pkg::tok_t [KeywordMax:0]  ents;
  logic [CntW-1:0]               n;
  logic                          start;
  logic                          id_char;

  assign id_char = is_letter(ch) || is_digit(ch) || ch == CH_UNDER;

  // keyword match over the held identifier
  always_comb begin
    logic m;
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int k = 0; k < klx_pkg::NUM_KW; k++) begin
      m = (wcnt == WcW'(klx_pkg::KW_LEN[k]));
      for (int i = 0; i < klx_pkg::KW_TEXT_MAX; i++) begin
        if (i < int'(klx_pkg::KW_LEN[k]) && wbuf[i] != klx_pkg::KW_TEXT[k][i]) m = 1'b0;
      end
      if (m && !kw_hit) begin
        kw_hit = 1'b1;
        kw_idx = 4'(k);
      end
    end
  end

  // identifier flush: keyword, tail of a long name, or the held characters
  always_comb begin
    fl_ents = '0;
    fl_n    = CntW'(1);
    if (wlong) begin
      fl_ents[0] = mk(klx_pkg::K_ID, wbuf[0], 1'b1, 1'b1);
    end else if (kw_hit) begin
      fl_ents[0] = mk(klx_pkg::K_KW0 + {2'b00, kw_idx}, 8'h00, 1'b0, 1'b1);
    end else begin
      for (int i = 0; i < KeywordMax; i++) begin
        fl_ents[i] = mk(klx_pkg::K_ID, wbuf[i], 1'b1, WcW'(i + 1) == wcnt);
      end
      fl_n = CntW'(wcnt);
    end
  end

  assign str_fl = (wcnt != '0) ? mk(klx_pkg::K_STRING, wbuf[0], 1'b1, 1'b1)
                               : mk(klx_pkg::K_STRING, 8'h00, 1'b0, 1'b1);

  always_comb begin
    unique case (pend)
      CH_LT:    begin op_second = CH_EQ;    op_two = klx_pkg::K_LE;  op_one = klx_pkg::K_LT;     end
      CH_GT:    begin op_second = CH_EQ;    op_two = klx_pkg::K_GE;  op_one = klx_pkg::K_GT;     end
      CH_EQ:    begin op_second = CH_EQ;    op_two = klx_pkg::K_EQ;  op_one = klx_pkg::K_ASSIGN; end
      CH_PLUS:  begin op_second = CH_PLUS;  op_two = klx_pkg::K_INC; op_one = klx_pkg::K_ADD;    end
      CH_MINUS: begin op_second = CH_MINUS; op_two = klx_pkg::K_DEC; op_one = klx_pkg::K_SUB;    end
      default:  begin op_second = CH_EQ;    op_two = klx_pkg::K_NE;  op_one = klx_pkg::K_ERROR;  end
    endcase
  end

  // classification of a byte that opens a token
  always_comb begin
    st_mode = MODE_IDLE;
    st_emit = 1'b0;
    st_kind = klx_pkg::K_SEMI;
    unique case (ch)
      CH_LT, CH_GT, CH_EQ, CH_PLUS, CH_MINUS, CH_BANG: st_mode = MODE_OP;
      CH_SEMI:   begin st_emit = 1'b1; st_kind = klx_pkg::K_SEMI;   end
      CH_POPEN:  begin st_emit = 1'b1; st_kind = klx_pkg::K_POPEN;  end
      CH_PCLOSE: begin st_emit = 1'b1; st_kind = klx_pkg::K_PCLOSE; end
      CH_PCT:    begin st_emit = 1'b1; st_kind = klx_pkg::K_MOD;    end
      CH_STAR:   begin st_emit = 1'b1; st_kind = klx_pkg::K_MULT;   end
      CH_SLASH:  begin st_emit = 1'b1; st_kind = klx_pkg::K_DIV;    end
      CH_QUOTE:  st_mode = MODE_STRING;
      default: begin
        if (is_letter(ch) || ch == CH_UNDER) st_mode = MODE_IDENT;
        else if (is_digit(ch))               st_mode = MODE_INT;
      end
    endcase
  end

  always_comb begin
    ents       = '0;
    n          = '0;
    start      = 1'b0;
    mode_next  = mode;
    pend_next  = pend;
    wbuf_next  = wbuf;
    wcnt_next  = wcnt;
    wlong_next = wlong;
    if (end_of_input) begin
      unique case (mode)
        MODE_OP:     begin ents[0] = mk(op_one, 8'h00, 1'b0, 1'b1); n = CntW'(1); end
        MODE_IDENT: begin
          for (int i = 0; i < KeywordMax; i++) ents[i] = fl_ents[i];
          n = fl_n;
        end
        MODE_INT:    begin ents[0] = mk(klx_pkg::K_INT, wbuf[0], 1'b1, 1'b1); n = CntW'(1); end
        MODE_STRING: begin ents[0] = str_fl; n = CntW'(1); end
        default: ;
      endcase
      ents[n[IdxW-1:0]] = mk(klx_pkg::K_END, 8'h00, 1'b0, 1'b1);
      n          = n + CntW'(1);
      mode_next  = MODE_IDLE;
      pend_next  = 8'h00;
      wcnt_next  = '0;
      wlong_next = 1'b0;
    end else begin
      unique case (mode)
        MODE_OP: begin
          if (ch == op_second) begin
            ents[0]   = mk(op_two, 8'h00, 1'b0, 1'b1);
            mode_next = MODE_IDLE;
          end else begin
            ents[0] = mk(op_one, 8'h00, 1'b0, 1'b1);
            start   = 1'b1;
          end
          n = CntW'(1);
        end
        MODE_IDENT: begin
          if (id_char) begin
            if (wlong) begin
              ents[0]      = mk(klx_pkg::K_ID, wbuf[0], 1'b1, 1'b0);
              n            = CntW'(1);
              wbuf_next[0] = ch;
            end else if (wcnt < WcW'(KeywordMax)) begin
              wbuf_next[wcnt[BufIdxW-1:0]] = ch;
              wcnt_next = wcnt + WcW'(1);
            end else begin
              // too long for a keyword: release the held text, keep one back
              for (int i = 0; i < KeywordMax; i++) ents[i] = mk(klx_pkg::K_ID, wbuf[i], 1'b1, 1'b0);
              n            = CntW'(KeywordMax);
              wbuf_next[0] = ch;
              wcnt_next    = WcW'(1);
              wlong_next   = 1'b1;
            end
          end else begin
            for (int i = 0; i < KeywordMax; i++) ents[i] = fl_ents[i];
            n     = fl_n;
            start = 1'b1;
          end
        end
        MODE_INT: begin
          if (is_digit(ch)) begin
            ents[0]      = mk(klx_pkg::K_INT, wbuf[0], 1'b1, 1'b0);
            wbuf_next[0] = ch;
          end else begin
            ents[0] = mk(klx_pkg::K_INT, wbuf[0], 1'b1, 1'b1);
            start   = 1'b1;
          end
          n = CntW'(1);
        end
        MODE_STRING: begin
          if (ch == CH_QUOTE) begin
            ents[0]   = str_fl;
            n         = CntW'(1);
            mode_next = MODE_IDLE;
          end else begin
            if (wcnt != '0) begin
              ents[0] = mk(klx_pkg::K_STRING, wbuf[0], 1'b1, 1'b0);
              n       = CntW'(1);
            end
            wbuf_next[0] = ch;
            wcnt_next    = WcW'(1);
          end
        end
        default: start = 1'b1;
      endcase
      // the terminating byte is scanned again as a token start
      if (start) begin
        mode_next = st_mode;
        if (st_mode == MODE_OP) pend_next = ch;
        if (st_mode == MODE_STRING) wcnt_next = '0;
        if (st_mode == MODE_IDENT) begin
          wbuf_next[0] = ch;
          wcnt_next    = WcW'(1);
          wlong_next   = 1'b0;
        end
        if (st_mode == MODE_INT) begin
          wbuf_next[0] = ch;
          wcnt_next    = WcW'(1);
        end
        if (st_emit) begin
          ents[n[IdxW-1:0]] = mk(st_kind, 8'h00, 1'b0, 1'b1);
          n = n + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      pend  <= 8'h00;
      wcnt  <= '0;
      wlong <= 1'b0;
    end else if (take) begin
      mode  <= mode_next;
      pend  <= pend_next;
      wcnt  <= wcnt_next;
      wlong <= wlong_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) wbuf <= wbuf_next;
  end

  assign cmd_push = take && (n != '0);
  assign cmd_ents = ents;
  assign cmd_n    = n;

`ifndef SYNTHESIS
  a_long_holds_one: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_IDENT && wlong) |-> wcnt == WcW'(1))
    else $error("long identifier holds more than one character");
  a_eoi_idle: assert property (@(posedge clk) disable iff (rst)
    (take && end_of_input) |=> (mode == MODE_IDLE && wcnt == '0))
    else $error("scanner not back at start after end of input");
`endif

endmodule

// ----- rtl/klx_cmdq.sv -----
// ----------------------------------------------------------------------------
// klx_cmdq
// Short register queue of command words between scanner front and back.
// ----------------------------------------------------------------------------
module klx_cmdq #(
  parameter int Width = 16,
  parameter int Depth = klx_pkg::CMDQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [Width-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [Width-1:0] rd_data,
  output logic             empty
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem [Depth];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  cnt;

  assign full    = (cnt == CntW'(Depth));
  assign empty   = (cnt == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      if (rd_en) rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      if (wr_en && !rd_en)      cnt <= cnt + CntW'(1);
      else if (rd_en && !wr_en) cnt <= cnt - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !rd_en) |-> !full)
    else $error("command queue overrun");
`endif

endmodule

// ----- rtl/klx_back.sv -----
// ----------------------------------------------------------------------------
// klx_back
// Result sequencer: steps through the words of the command at the queue
// head, one result word per pop, and retires the command after its last.
// ----------------------------------------------------------------------------
module klx_back #(
  parameter int  KeywordMax = klx_pkg::KEYWORD_MAX_DEF,
  localparam int CntW       = $clog2(KeywordMax + 2)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  klx_pkg::tok_t [KeywordMax:0] q_ents,
  input  logic [CntW-1:0]              q_n,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  logic                         pop,
  output logic                         empty,
  output logic [5:0]                   kind,
  output logic [7:0]                   text_char,
  output logic                         has_char,
  output logic                         last
);

  localparam int IdxW = $clog2(KeywordMax + 1);

  logic [IdxW-1:0] idx;
  logic            take;
  logic            at_end;
  klx_pkg::tok_t   cur;

  assign take   = pop && !q_empty;
  assign at_end = (CntW'(idx) + CntW'(1) == q_n);
  assign q_pop  = take && at_end;
  assign cur    = q_ents[idx];

  assign empty     = q_empty;
  assign kind      = cur.kind;
  assign text_char = cur.text_char;
  assign has_char  = cur.has_char;
  assign last      = cur.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= at_end ? '0 : idx + IdxW'(1);
    end
  end

`ifndef SYNTHESIS
  a_idx_in_cmd: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> (q_n != '0 && CntW'(idx) < q_n))
    else $error("result index outside head command");
  a_idx_rewinds: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> idx == '0)
    else $error("index not rewound after command retired");
`endif

endmodule

// ----- rtl/keyword_lexer_stream_top.sv -----
// ----------------------------------------------------------------------------
// keyword_lexer_stream_top
// Streaming keyword lexer: source bytes in, token result words out.
// ----------------------------------------------------------------------------
//  channel  | handshake        | fields
//  ---------+------------------+-----------------------------------------
//  input    | push / full      | ch[7:0], end_of_input
//  result   | pop / empty      | kind[5:0], text_char[7:0], has_char, last
//
//  One byte is taken every cycle while the command queue has room; the
//  front scans it in that cycle and queues at most one command of up to
//  KeywordMax+1 result words. The back hands out one result word per pop,
//  so a byte that releases several words occupies the back for as many
//  pops. Reset (rst, synchronous) empties the queue and returns the
//  scanner to its start state. full rises only when the queue is full.
// ----------------------------------------------------------------------------
module keyword_lexer_stream_top #(
  parameter int KeywordMax = klx_pkg::KEYWORD_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] ch,
  input  logic       end_of_input,
  input  logic       pop,
  output logic       empty,
  output logic [5:0] kind,
  output logic [7:0] text_char,
  output logic       has_char,
  output logic       last
);

  localparam int CntW = $clog2(KeywordMax + 2);
  localparam int CmdW = (KeywordMax + 1) * $bits(klx_pkg::tok_t) + CntW;

  logic                         take;
  logic                         cmd_push;
  klx_pkg::tok_t [KeywordMax:0] cmd_ents;
  logic [CntW-1:0]              cmd_n;
  logic [CmdW-1:0]              q_wr, q_rd;
  klx_pkg::tok_t [KeywordMax:0] q_ents;
  logic [CntW-1:0]              q_n;
  logic                         q_empty, q_pop;

  assign take = push && !full;
  assign q_wr = {cmd_ents, cmd_n};
  assign {q_ents, q_n} = q_rd;

  klx_front #(.KeywordMax(KeywordMax)) u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .ch           (ch),
    .end_of_input (end_of_input),
    .cmd_push     (cmd_push),
    .cmd_ents     (cmd_ents),
    .cmd_n        (cmd_n)
  );

  klx_cmdq #(.Width(CmdW), .Depth(klx_pkg::CMDQ_DEPTH)) u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (q_wr),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  klx_back #(.KeywordMax(KeywordMax)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_ents    (q_ents),
    .q_n       (q_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .kind      (kind),
    .text_char (text_char),
    .has_char  (has_char),
    .last      (last)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for keyword_lexer_stream_top. Source bytes and
// end-of-input marks go in through the push/full queue port. A scanner
// model inside the scoreboard class predicts every token word. Each word
// popped from the block is compared field by field with the oldest
// prediction. Both sides idle at random, and the receiver stalls once for a
// long stretch so that the block fills up.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 24;
  localparam int WORD_TARGET  = 116;

  // --------------------------------------------------------------------------
  // Scanner model and store of expected token words
  // --------------------------------------------------------------------------
  class lexer_scoreboard;
    typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_OP, SCAN_IDENT, SCAN_INT, SCAN_STRING
    } scan_e;

    string kw_names[klx_pkg::NUM_KW] = '{"print", "if", "then", "else", "get", "end",
                                         "while", "do", "for", "and", "or", "not"};

    scan_e          mode;
    logic [7:0]     op_char;
    logic [7:0]     held [klx_pkg::KEYWORD_MAX_DEF];
    int             count;
    bit             long_word;
    klx_pkg::tok_t  token_q[$];
    int             errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      mode      = SCAN_IDLE;
      op_char   = 8'h00;
      count     = 0;
      long_word = 1'b0;
      foreach (held[i]) held[i] = 8'h00;
    endfunction

    function int outstanding();
      return token_q.size();
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function void add(logic [5:0] k, logic [7:0] c, bit has, bit fin);
      klx_pkg::tok_t t;
      t.kind      = k;
      t.text_char = has ? c : 8'h00;
      t.has_char  = has;
      t.last      = fin;
      token_q.push_back(t);
    endfunction

    function void open_token(logic [7:0] c);
      mode = SCAN_IDLE;
      case (c)
        "<", ">", "=", "+", "-", "!": begin
          mode    = SCAN_OP;
          op_char = c;
        end
        ";":  add(klx_pkg::K_SEMI, 8'h00, 1'b0, 1'b1);
        "(":  add(klx_pkg::K_POPEN, 8'h00, 1'b0, 1'b1);
        ")":  add(klx_pkg::K_PCLOSE, 8'h00, 1'b0, 1'b1);
        "%":  add(klx_pkg::K_MOD, 8'h00, 1'b0, 1'b1);
        "*":  add(klx_pkg::K_MULT, 8'h00, 1'b0, 1'b1);
        "/":  add(klx_pkg::K_DIV, 8'h00, 1'b0, 1'b1);
        "\"": begin
          mode  = SCAN_STRING;
          count = 0;
        end
        default: begin
          if (is_letter(c) || c == "_") begin
            mode      = SCAN_IDENT;
            held[0]   = c;
            count     = 1;
            long_word = 1'b0;
          end else if (is_digit(c)) begin
            mode    = SCAN_INT;
            held[0] = c;
            count   = 1;
          end
        end
      endcase
    endfunction

    // true when c completed a two-byte operator
    function bit close_operator(logic [7:0] c, bit have_c);
      logic [7:0] second;
      logic [5:0] two, one;
      case (op_char)
        "<": begin
          second = "="; two = klx_pkg::K_LE;  one = klx_pkg::K_LT;
        end
        ">": begin
          second = "="; two = klx_pkg::K_GE;  one = klx_pkg::K_GT;
        end
        "=": begin
          second = "="; two = klx_pkg::K_EQ;  one = klx_pkg::K_ASSIGN;
        end
        "+": begin
          second = "+"; two = klx_pkg::K_INC; one = klx_pkg::K_ADD;
        end
        "-": begin
          second = "-"; two = klx_pkg::K_DEC; one = klx_pkg::K_SUB;
        end
        default: begin
          second = "="; two = klx_pkg::K_NE;  one = klx_pkg::K_ERROR;
        end
      endcase
      mode = SCAN_IDLE;
      if (have_c && c == second) begin
        add(two, 8'h00, 1'b0, 1'b1);
        return 1'b1;
      end
      add(one, 8'h00, 1'b0, 1'b1);
      return 1'b0;
    endfunction

    function void flush_ident();
      int n;
      bit hit;
      if (long_word) begin
        add(klx_pkg::K_ID, held[0], 1'b1, 1'b1);
        return;
      end
      n = (count > klx_pkg::KEYWORD_MAX_DEF) ? klx_pkg::KEYWORD_MAX_DEF : count;
      if (n == 0) n = 1;
      for (int k = 0; k < klx_pkg::NUM_KW; k++) begin
        hit = (kw_names[k].len() == n);
        for (int i = 0; i < n && hit; i++)
          if (kw_names[k][i] != held[i]) hit = 1'b0;
        if (hit) begin
          add(klx_pkg::K_KW0 + 6'(k), 8'h00, 1'b0, 1'b1);
          return;
        end
      end
      for (int i = 0; i < n; i++)
        add(klx_pkg::K_ID, held[i], 1'b1, i + 1 == n);
    endfunction

    function void flush_string();
      if (count != 0) add(klx_pkg::K_STRING, held[0], 1'b1, 1'b1);
      else add(klx_pkg::K_STRING, 8'h00, 1'b0, 1'b1);
    endfunction

    function void note_input(logic [7:0] c, bit eoi);
      if (eoi) begin
        case (mode)
          SCAN_OP:     void'(close_operator(8'h00, 1'b0));
          SCAN_IDENT:  flush_ident();
          SCAN_INT:    add(klx_pkg::K_INT, held[0], 1'b1, 1'b1);
          SCAN_STRING: flush_string();
          default:     ;
        endcase
        add(klx_pkg::K_END, 8'h00, 1'b0, 1'b1);
        restart();
        return;
      end
      case (mode)
        SCAN_OP: begin
          if (!close_operator(c, 1'b1)) open_token(c);
        end
        SCAN_IDENT: begin
          if (is_letter(c) || is_digit(c) || c == "_") begin
            if (long_word) begin
              add(klx_pkg::K_ID, held[0], 1'b1, 1'b0);
              held[0] = c;
            end else if (count < klx_pkg::KEYWORD_MAX_DEF) begin
              held[count] = c;
              count++;
            end else begin
              // too long for a keyword: release the held text and stream on
              for (int i = 0; i < klx_pkg::KEYWORD_MAX_DEF; i++)
                add(klx_pkg::K_ID, held[i], 1'b1, 1'b0);
              held[0]   = c;
              count     = 1;
              long_word = 1'b1;
            end
          end else begin
            flush_ident();
            open_token(c);
          end
        end
        SCAN_INT: begin
          if (is_digit(c)) begin
            add(klx_pkg::K_INT, held[0], 1'b1, 1'b0);
            held[0] = c;
          end else begin
            add(klx_pkg::K_INT, held[0], 1'b1, 1'b1);
            open_token(c);
          end
        end
        SCAN_STRING: begin
          if (c == "\"") begin
            flush_string();
            mode = SCAN_IDLE;
          end else begin
            if (count != 0) add(klx_pkg::K_STRING, held[0], 1'b1, 1'b0);
            held[0] = c;
            count   = 1;
          end
        end
        default: open_token(c);
      endcase
    endfunction

    function void check_result(klx_pkg::tok_t got);
      klx_pkg::tok_t want;
      if (token_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: kind=%0d char=%02h has=%0b last=%0b",
                   got.kind, got.text_char, got.has_char, got.last);
        return;
      end
      want = token_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp kind=%0d char=%02h has=%0b last=%0b, ",
                    "got kind=%0d char=%02h has=%0b last=%0b"},
                   want.kind, want.text_char, want.has_char, want.last,
                   got.kind, got.text_char, got.has_char, got.last);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and clock
  // --------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push;
  logic       full;
  logic [7:0] ch;
  logic       end_of_input;
  logic       pop;
  logic       empty;
  logic [5:0] kind;
  logic [7:0] text_char;
  logic       has_char;
  logic       last;

  keyword_lexer_stream_top u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .ch           (ch),
    .end_of_input (end_of_input),
    .pop          (pop),
    .empty        (empty),
    .kind         (kind),
    .text_char    (text_char),
    .has_char     (has_char),
    .last         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lexer_scoreboard sb = new();
  int sent         = 0;
  bit hold_req     = 1'b0;
  int stuck_cycles = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [7:0] c, input bit e);
    int gap;
    gap = (sent % 40 < 10) ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push         <= 1'b1;
    ch           <= c;
    end_of_input <= e;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_input(c, e);
    sent++;
    if (sent == 60) hold_req = 1'b1;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + (r - 26));
    if (r < 62) return 8'("0" + (r - 52));
    return "_";
  endfunction

  task automatic emit_token();
    string      ops;
    int         sel;
    int         len;
    logic [7:0] b;
    ops = "<>=+-!;()%*/";
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      send_text(sb.kw_names[$urandom_range(0, klx_pkg::NUM_KW - 1)]);
    end else if (sel < 30) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
      b = word_char();
      if (b >= "0" && b <= "9") b = "_";
      send_word(b, 1'b0);
      repeat (len - 1) send_word(word_char(), 1'b0);
    end else if (sel < 42) begin
      len = $urandom_range(1, 6);
      repeat (len) send_word(8'("0" + $urandom_range(0, 9)), 1'b0);
    end else if (sel < 52) begin
      send_word("\"", 1'b0);
      len = $urandom_range(0, 5);
      repeat (len) begin
        do b = 8'($urandom_range(0, 255)); while (b == "\"");
        send_word(b, 1'b0);
      end
      if ($urandom_range(0, 9) != 0) send_word("\"", 1'b0);
    end else if (sel < 75) begin
      b = ops[$urandom_range(0, ops.len() - 1)];
      send_word(b, 1'b0);
      case ($urandom_range(0, 2))
        1: send_word((b == "+" || b == "-") ? b : 8'("="), 1'b0);
        2: send_word(ops[$urandom_range(0, ops.len() - 1)], 1'b0);
        default: ;
      endcase
    end else if (sel < 85) begin
      case ($urandom_range(0, 2))
        0: send_word(" ", 1'b0);
        1: send_word("\t", 1'b0);
        default: send_word("\n", 1'b0);
      endcase
    end else if (sel < 95) begin
      send_word(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_word(8'($urandom_range(0, 255)), 1'b1);
    end
    if ($urandom_range(0, 9) < 6) send_word(" ", 1'b0);
  endtask

  initial begin
    push         = 1'b0;
    ch           = 8'h00;
    end_of_input = 1'b0;
    pop          = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all two-byte operators, a lone bang, the tokens ; ( ) % * /,
    // an empty string, a high byte outside a string, a word cut by the end
    send_text("<=>===++--!=!;()%*/");
    send_text("\"\"");
    send_word(8'hFF, 1'b0);
    send_text("x");
    send_word(8'hA5, 1'b1);

    while (sent < WORD_TARGET) emit_token();
    send_word(8'($urandom_range(0, 255)), 1'b1);
    @(negedge clk);
    push <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver side
  // --------------------------------------------------------------------------
  initial begin
    int rx_gap;
    int rx_cycle;
    rx_gap   = 0;
    rx_cycle = 0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long stall so the command queue fills and full rises
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (rx_gap > 0) begin
        pop <= 1'b0;
        rx_gap--;
      end else begin
        pop <= 1'b1;
        if (rx_cycle % 64 >= 16 && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
      end
      rx_cycle++;
    end
  end

  always @(posedge clk) begin
    klx_pkg::tok_t got;
    got.kind      = kind;
    got.text_char = text_char;
    got.has_char  = has_char;
    got.last      = last;
    if (!rst && pop && !empty) sb.check_result(got);
  end

  // watchdog: cycles in a row with no word moved on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule

// ----- sim.f -----
rtl/klx_pkg.sv
rtl/klx_front.sv
rtl/klx_cmdq.sv
rtl/klx_back.sv
rtl/keyword_lexer_stream_top.sv
tb/tb_top.sv
